// File: rtl/core/alsc_pkg.sv
// Shared types, codes and reset values for the audio level structure classifier.
package alsc_pkg;

  localparam logic [1:0] CLASS_SILENT = 2'd0;
  localparam logic [1:0] CLASS_SOFT   = 2'd1;
  localparam logic [1:0] CLASS_LOUD   = 2'd2;

  localparam logic [2:0] REG_SILENT_FLOOR_MIN      = 3'd0;
  localparam logic [2:0] REG_SILENT_FLOOR_CEILING  = 3'd1;
  localparam logic [2:0] REG_LOUD_LEVEL_MAX        = 3'd2;
  localparam logic [2:0] REG_LOUD_LEVEL_MIN        = 3'd3;
  localparam logic [2:0] REG_SUB_BASS_LOUD_FLOOR   = 3'd4;
  localparam logic [2:0] REG_SUB_BASS_SOFT_CEILING = 3'd5;
  localparam logic [2:0] REG_RATIO_FACTORS         = 3'd6;
  localparam logic [2:0] REG_HOLD_TIMES            = 3'd7;

  localparam logic [15:0] RST_SILENT_FLOOR_MIN      = 16'd66;
  localparam logic [15:0] RST_SILENT_FLOOR_CEILING  = 16'd1311;
  localparam logic [15:0] RST_LOUD_LEVEL_MAX        = 16'd16384;
  localparam logic [15:0] RST_LOUD_LEVEL_MIN        = 16'd3277;
  localparam logic [15:0] RST_SUB_BASS_LOUD_FLOOR   = 16'd39322;
  localparam logic [15:0] RST_SUB_BASS_SOFT_CEILING = 16'd19661;
  localparam logic [63:0] RST_RATIO_FACTORS         = 64'd184374905851944960;
  localparam logic [59:0] RST_HOLD_TIMES            = 60'd19426516194564645;

  localparam int SAMPLES_BITS = 13;
  localparam int MAX_BLOCK    = 4096;
  localparam int HOLD_BITS    = 18;

  typedef struct packed {
    logic [15:0] silent_floor_min;
    logic [15:0] silent_floor_ceiling;
    logic [15:0] loud_level_max;
    logic [15:0] loud_level_min;
    logic [15:0] sub_bass_loud_floor;
    logic [15:0] sub_bass_soft_ceiling;
    logic [63:0] ratio_factors;
    logic [59:0] hold_times;
  } cfg_t;

  // Hold time in samples for a transition; holds are stored in 64-sample units.
  function automatic logic [HOLD_BITS-1:0] hold_for(input logic [59:0] holds,
                                                     input logic [1:0] from_class,
                                                     input logic [1:0] to_class);
    logic [11:0] field;
    field = 12'd0;
    if (from_class == to_class) begin
      field = 12'd0;
    end else if (from_class == CLASS_SILENT) begin
      field = holds[11:0];
    end else if (from_class == CLASS_SOFT) begin
      field = (to_class == CLASS_SILENT) ? holds[23:12] : holds[35:24];
    end else begin
      field = (to_class == CLASS_SILENT) ? holds[47:36] : holds[59:48];
    end
    return {field, 6'b000000};
  endfunction

endpackage

// File: rtl/core/alsc_cfg.sv
// Configuration register file written through the plain write port.
module alsc_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [63:0]        wr_data,
  output alsc_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.silent_floor_min      <= alsc_pkg::RST_SILENT_FLOOR_MIN;
      cfg.silent_floor_ceiling  <= alsc_pkg::RST_SILENT_FLOOR_CEILING;
      cfg.loud_level_max        <= alsc_pkg::RST_LOUD_LEVEL_MAX;
      cfg.loud_level_min        <= alsc_pkg::RST_LOUD_LEVEL_MIN;
      cfg.sub_bass_loud_floor   <= alsc_pkg::RST_SUB_BASS_LOUD_FLOOR;
      cfg.sub_bass_soft_ceiling <= alsc_pkg::RST_SUB_BASS_SOFT_CEILING;
      cfg.ratio_factors         <= alsc_pkg::RST_RATIO_FACTORS;
      cfg.hold_times            <= alsc_pkg::RST_HOLD_TIMES;
    end else if (wr_en) begin
      case (wr_index)
        alsc_pkg::REG_SILENT_FLOOR_MIN:      cfg.silent_floor_min      <= wr_data[15:0];
        alsc_pkg::REG_SILENT_FLOOR_CEILING:  cfg.silent_floor_ceiling  <= wr_data[15:0];
        alsc_pkg::REG_LOUD_LEVEL_MAX:        cfg.loud_level_max        <= wr_data[15:0];
        alsc_pkg::REG_LOUD_LEVEL_MIN:        cfg.loud_level_min        <= wr_data[15:0];
        alsc_pkg::REG_SUB_BASS_LOUD_FLOOR:   cfg.sub_bass_loud_floor   <= wr_data[15:0];
        alsc_pkg::REG_SUB_BASS_SOFT_CEILING: cfg.sub_bass_soft_ceiling <= wr_data[15:0];
        alsc_pkg::REG_RATIO_FACTORS:         cfg.ratio_factors         <= wr_data;
        alsc_pkg::REG_HOLD_TIMES:            cfg.hold_times            <= wr_data[59:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/alsc_floor.sv
// Adaptive noise floor stage: snaps down at once, creeps up while quiet.
module alsc_floor #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  alsc_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [LEVEL_BITS-1:0]                in_rms,
  input  logic [LEVEL_BITS-1:0]                in_peak,
  input  logic [15:0]                          in_share,
  input  logic                                 in_ringing,
  input  logic [alsc_pkg::SAMPLES_BITS-1:0]    in_samples,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [LEVEL_BITS-1:0]                out_rms,
  output logic [LEVEL_BITS-1:0]                out_peak,
  output logic [15:0]                          out_share,
  output logic                                 out_ringing,
  output logic [alsc_pkg::SAMPLES_BITS-1:0]    out_samples,
  output logic [LEVEL_BITS-1:0]                out_floor
);

  localparam int CW  = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;
  localparam int PRW = LEVEL_BITS + 16;

  logic [LEVEL_BITS-1:0] noise_floor;
  logic [LEVEL_BITS-1:0] noise_floor_next;
  logic [LEVEL_BITS-1:0] diff;
  logic [PRW-1:0]        creep_prod;
  logic                  quiet;

  assign in_ready   = !out_valid || out_ready;
  assign diff       = in_rms - noise_floor;
  assign creep_prod = PRW'(cfg.ratio_factors[63:48]) * PRW'(diff);
  assign quiet      = (CW'(in_rms) < CW'(cfg.silent_floor_ceiling)) && !in_ringing;

  always_comb begin
    if (in_rms < noise_floor) begin
      noise_floor_next = in_rms;
    end else if (quiet) begin
      noise_floor_next = noise_floor + creep_prod[PRW-1:16];
    end else begin
      noise_floor_next = noise_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      noise_floor <= '1;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        noise_floor <= noise_floor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rms     <= in_rms;
      out_peak    <= in_peak;
      out_share   <= in_share;
      out_ringing <= in_ringing;
      out_samples <= in_samples;
      out_floor   <= noise_floor_next;
    end
  end

endmodule

// File: rtl/core/alsc_thresh.sv
// Threshold stage: silent and loud thresholds from the noise floor and the peak.
module alsc_thresh #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  alsc_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [LEVEL_BITS-1:0]                in_rms,
  input  logic [LEVEL_BITS-1:0]                in_peak,
  input  logic [15:0]                          in_share,
  input  logic                                 in_ringing,
  input  logic [alsc_pkg::SAMPLES_BITS-1:0]    in_samples,
  input  logic [LEVEL_BITS-1:0]                in_floor,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [LEVEL_BITS-1:0]                out_rms,
  output logic [15:0]                          out_share,
  output logic                                 out_ringing,
  output logic [alsc_pkg::SAMPLES_BITS-1:0]    out_samples,
  output logic [((LEVEL_BITS + 4 > 16) ? LEVEL_BITS + 4 : 16)-1:0] out_silent_thr,
  output logic [15:0]                          out_loud_thr
);

  localparam int PRW = LEVEL_BITS + 16;
  localparam int PW  = (LEVEL_BITS + 4 > 16) ? LEVEL_BITS + 4 : 16;

  logic [PRW-1:0] margin_prod;
  logic [PRW-1:0] silent_peak_prod;
  logic [PRW-1:0] loud_peak_prod;
  logic [PW-1:0]  margin_lvl;
  logic [PW-1:0]  silent_peak_lvl;
  logic [PW-1:0]  loud_peak_lvl;
  logic [PW-1:0]  capped;
  logic [PW-1:0]  silent_lo;
  logic [PW-1:0]  silent_thr;
  logic [PW-1:0]  loud_lo;
  logic [PW-1:0]  loud_capped;
  logic [15:0]    loud_thr;

  assign in_ready = !out_valid || out_ready;

  assign margin_prod      = PRW'(in_floor) * PRW'(cfg.ratio_factors[15:0]);
  assign silent_peak_prod = PRW'(in_peak) * PRW'(cfg.ratio_factors[31:16]);
  assign loud_peak_prod   = PRW'(in_peak) * PRW'(cfg.ratio_factors[47:32]);

  assign margin_lvl      = PW'(margin_prod[PRW-1:12]);
  assign silent_peak_lvl = PW'(silent_peak_prod[PRW-1:12]);
  assign loud_peak_lvl   = PW'(loud_peak_prod[PRW-1:12]);

  always_comb begin
    capped = (margin_lvl < PW'(cfg.silent_floor_ceiling)) ?
             margin_lvl : PW'(cfg.silent_floor_ceiling);
    silent_lo = (PW'(cfg.silent_floor_min) > capped) ? PW'(cfg.silent_floor_min) : capped;
    silent_thr = (silent_peak_lvl > silent_lo) ? silent_peak_lvl : silent_lo;
    loud_lo = (PW'(cfg.loud_level_min) > loud_peak_lvl) ?
              PW'(cfg.loud_level_min) : loud_peak_lvl;
    loud_capped = (PW'(cfg.loud_level_max) < loud_lo) ? PW'(cfg.loud_level_max) : loud_lo;
    if (in_peak != '0) begin
      loud_thr = loud_capped[15:0];
    end else begin
      loud_thr = cfg.loud_level_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rms        <= in_rms;
      out_share      <= in_share;
      out_ringing    <= in_ringing;
      out_samples    <= in_samples;
      out_silent_thr <= silent_thr;
      out_loud_thr   <= loud_thr;
    end
  end

endmodule

// File: rtl/core/alsc_debounce.sv
// Class decision and debounce stage with the result register.
module alsc_debounce #(
  parameter int LEVEL_BITS   = 16,
  parameter int PENDING_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  alsc_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [LEVEL_BITS-1:0]                in_rms,
  input  logic [15:0]                          in_share,
  input  logic                                 in_ringing,
  input  logic [alsc_pkg::SAMPLES_BITS-1:0]    in_samples,
  input  logic [((LEVEL_BITS + 4 > 16) ? LEVEL_BITS + 4 : 16)-1:0] in_silent_thr,
  input  logic [15:0]                          in_loud_thr,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_class,
  output logic                                 out_changed
);

  localparam int PW = (LEVEL_BITS + 4 > 16) ? LEVEL_BITS + 4 : 16;
  localparam int CW = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;
  localparam int SW = ((PENDING_BITS > alsc_pkg::SAMPLES_BITS) ?
                       PENDING_BITS : alsc_pkg::SAMPLES_BITS) + 1;
  localparam int HW = (PENDING_BITS > alsc_pkg::HOLD_BITS) ?
                      PENDING_BITS : alsc_pkg::HOLD_BITS;

  logic [1:0]              current_class;
  logic [1:0]              current_class_next;
  logic [1:0]              pending_class;
  logic [1:0]              pending_class_next;
  logic [PENDING_BITS-1:0] pending_samples;
  logic [PENDING_BITS-1:0] pending_samples_next;
  logic                    changed_next;
  logic [1:0]              desired;
  logic                    over_block;
  logic [alsc_pkg::SAMPLES_BITS-1:0] samples_c;
  logic [PENDING_BITS-1:0] base;
  logic [SW-1:0]           sum;
  logic [PENDING_BITS-1:0] sum_sat;
  logic [alsc_pkg::HOLD_BITS-1:0] hold;

  assign in_ready   = !out_valid || out_ready;
  assign over_block = {19'd0, in_samples} > 32'(alsc_pkg::MAX_BLOCK);
  assign samples_c  = over_block ? alsc_pkg::SAMPLES_BITS'(alsc_pkg::MAX_BLOCK) : in_samples;

  always_comb begin
    if ((PW'(in_rms) < in_silent_thr) && !in_ringing) begin
      desired = alsc_pkg::CLASS_SILENT;
    end else if (in_share >= cfg.sub_bass_loud_floor) begin
      desired = alsc_pkg::CLASS_LOUD;
    end else if ((in_share <= cfg.sub_bass_soft_ceiling) &&
                 (CW'(in_rms) < CW'(in_loud_thr))) begin
      desired = alsc_pkg::CLASS_SOFT;
    end else if (CW'(in_rms) >= CW'(in_loud_thr)) begin
      desired = alsc_pkg::CLASS_LOUD;
    end else begin
      desired = alsc_pkg::CLASS_SOFT;
    end
  end

  assign base    = (desired != pending_class) ? '0 : pending_samples;
  assign sum     = SW'(base) + SW'(samples_c);
  assign sum_sat = (sum > SW'({PENDING_BITS{1'b1}})) ? '1 : sum[PENDING_BITS-1:0];
  assign hold    = alsc_pkg::hold_for(cfg.hold_times, current_class, desired);

  always_comb begin
    current_class_next   = current_class;
    pending_class_next   = desired;
    pending_samples_next = sum_sat;
    changed_next         = 1'b0;
    if (desired == current_class) begin
      pending_class_next   = current_class;
      pending_samples_next = '0;
    end else if (HW'(sum_sat) >= HW'(hold)) begin
      current_class_next   = desired;
      pending_samples_next = '0;
      changed_next         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      current_class   <= alsc_pkg::CLASS_SILENT;
      pending_class   <= alsc_pkg::CLASS_SILENT;
      pending_samples <= '0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        current_class   <= current_class_next;
        pending_class   <= pending_class_next;
        pending_samples <= pending_samples_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_class   <= current_class_next;
      out_changed <= changed_next;
    end
  end

endmodule

// File: rtl/core/audio_level_structure_classifier.sv
// Top level of the audio level structure classifier.
// The result reaches m_tvalid through the input register, then the noise floor stage,
// threshold stage, debounce and result register. Throughput: one item per cycle unless
// m_tready stalls the output; every stage has its own register and takes a new
// item whenever the stage after it is empty or moving. Synchronous reset clears all
// valid flags, sets the noise floor to full scale and the class state to silent.
module audio_level_structure_classifier #(
  parameter int LEVEL_BITS   = 16,
  parameter int PENDING_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // rms_level, peak_level, sub_bass_share, block_samples, zero fill
  input  logic [((2 * LEVEL_BITS + 16 + alsc_pkg::SAMPLES_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // note_ringing
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // structure_class, zero fill
  output logic [7:0]  m_tdata,
  // class_changed
  output logic        m_tuser
);

  localparam int PW = (LEVEL_BITS + 4 > 16) ? LEVEL_BITS + 4 : 16;
  localparam int SB = alsc_pkg::SAMPLES_BITS;

  alsc_pkg::cfg_t cfg;

  logic                  v0;
  logic                  rdy0;
  logic [LEVEL_BITS-1:0] rms0;
  logic [LEVEL_BITS-1:0] peak0;
  logic [15:0]           share0;
  logic                  ring0;
  logic [SB-1:0]         smp0;

  logic                  fl_ready;
  logic                  v1;
  logic                  rdy1;
  logic [LEVEL_BITS-1:0] rms1;
  logic [LEVEL_BITS-1:0] peak1;
  logic [15:0]           share1;
  logic                  ring1;
  logic [SB-1:0]         smp1;
  logic [LEVEL_BITS-1:0] floor1;

  logic                  v2;
  logic                  rdy2;
  logic [LEVEL_BITS-1:0] rms2;
  logic [15:0]           share2;
  logic                  ring2;
  logic [SB-1:0]         smp2;
  logic [PW-1:0]         silent2;
  logic [15:0]           loud2;

  logic [1:0]            out_class;

  assign rdy0     = !v0 || fl_ready;
  assign s_tready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && s_tvalid) begin
      rms0   <= s_tdata[LEVEL_BITS-1:0];
      peak0  <= s_tdata[2*LEVEL_BITS-1:LEVEL_BITS];
      share0 <= s_tdata[2*LEVEL_BITS+15:2*LEVEL_BITS];
      smp0   <= s_tdata[2*LEVEL_BITS+16+SB-1:2*LEVEL_BITS+16];
      ring0  <= s_tuser;
    end
  end

  alsc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  alsc_floor #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_floor (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (v0),
    .in_ready    (fl_ready),
    .in_rms      (rms0),
    .in_peak     (peak0),
    .in_share    (share0),
    .in_ringing  (ring0),
    .in_samples  (smp0),
    .out_valid   (v1),
    .out_ready   (rdy1),
    .out_rms     (rms1),
    .out_peak    (peak1),
    .out_share   (share1),
    .out_ringing (ring1),
    .out_samples (smp1),
    .out_floor   (floor1)
  );

  alsc_thresh #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_thresh (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (v1),
    .in_ready       (rdy1),
    .in_rms         (rms1),
    .in_peak        (peak1),
    .in_share       (share1),
    .in_ringing     (ring1),
    .in_samples     (smp1),
    .in_floor       (floor1),
    .out_valid      (v2),
    .out_ready      (rdy2),
    .out_rms        (rms2),
    .out_share      (share2),
    .out_ringing    (ring2),
    .out_samples    (smp2),
    .out_silent_thr (silent2),
    .out_loud_thr   (loud2)
  );

  alsc_debounce #(
    .LEVEL_BITS   (LEVEL_BITS),
    .PENDING_BITS (PENDING_BITS)
  ) u_debounce (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (v2),
    .in_ready      (rdy2),
    .in_rms        (rms2),
    .in_share      (share2),
    .in_ringing    (ring2),
    .in_samples    (smp2),
    .in_silent_thr (silent2),
    .in_loud_thr   (loud2),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_class     (out_class),
    .out_changed   (m_tuser)
  );

  assign m_tdata = {6'b000000, out_class};

endmodule

// File: dv/audio_level_structure_classifier_checker.sv
// Checker that predicts every classifier result from the observed transfers and compares it.
module audio_level_structure_classifier_checker
  import alsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          outstanding,
  output int          blocks_checked,
  output int          changes_seen
);

  typedef struct packed {
    logic [1:0] cls;
    logic       changed;
  } verdict_t;

  cfg_t        cfg;
  logic [15:0] floor_level;
  logic [1:0]  cur_class;
  logic [1:0]  pend_class;
  logic [19:0] pend_samples;
  verdict_t    verdict_q[$];
  verdict_t    oldest;
  int          errs = 0;
  int          checked = 0;
  int          changes = 0;

  function automatic logic [63:0] hold_samples(input logic [1:0] from_c, input logic [1:0] to_c);
    int slot;
    if (from_c == to_c) begin
      return 64'd0;
    end
    case (from_c)
      CLASS_SILENT: slot = 0;
      CLASS_SOFT:   slot = (to_c == CLASS_SILENT) ? 1 : 2;
      default:      slot = (to_c == CLASS_SILENT) ? 3 : 4;
    endcase
    return 64'(cfg.hold_times[12 * slot +: 12]) * 64'd64;
  endfunction

  function automatic verdict_t classify_block(input logic [15:0] rms, input logic [15:0] peak,
                                              input logic [15:0] share, input logic ringing,
                                              input logic [12:0] n_raw);
    logic [63:0] n;
    logic [63:0] scaled;
    logic [63:0] silent_thr;
    logic [63:0] loud_thr;
    logic [63:0] total;
    logic [1:0]  want;
    verdict_t    v;
    n = (n_raw > MAX_BLOCK) ? 64'(MAX_BLOCK) : 64'(n_raw);

    if (rms < floor_level) begin
      floor_level = rms;
    end else if (rms < cfg.silent_floor_ceiling && !ringing) begin
      floor_level = floor_level +
        16'((64'(cfg.ratio_factors[63:48]) * 64'(rms - floor_level)) >> 16);
    end

    scaled = (64'(floor_level) * 64'(cfg.ratio_factors[15:0])) >> 12;
    silent_thr = (scaled < 64'(cfg.silent_floor_ceiling)) ? scaled :
                 64'(cfg.silent_floor_ceiling);
    if (silent_thr < 64'(cfg.silent_floor_min)) begin
      silent_thr = 64'(cfg.silent_floor_min);
    end
    scaled = (64'(peak) * 64'(cfg.ratio_factors[31:16])) >> 12;
    if (scaled > silent_thr) begin
      silent_thr = scaled;
    end

    if (peak != 16'd0) begin
      loud_thr = (64'(peak) * 64'(cfg.ratio_factors[47:32])) >> 12;
      if (loud_thr < 64'(cfg.loud_level_min)) begin
        loud_thr = 64'(cfg.loud_level_min);
      end
      if (loud_thr > 64'(cfg.loud_level_max)) begin
        loud_thr = 64'(cfg.loud_level_max);
      end
    end else begin
      loud_thr = 64'(cfg.loud_level_max);
    end

    if (64'(rms) < silent_thr && !ringing) begin
      want = CLASS_SILENT;
    end else if (share >= cfg.sub_bass_loud_floor) begin
      want = CLASS_LOUD;
    end else if (share <= cfg.sub_bass_soft_ceiling && 64'(rms) < loud_thr) begin
      want = CLASS_SOFT;
    end else if (64'(rms) >= loud_thr) begin
      want = CLASS_LOUD;
    end else begin
      want = CLASS_SOFT;
    end

    v.changed = 1'b0;
    if (want == cur_class) begin
      pend_samples = 20'd0;
      pend_class = cur_class;
    end else begin
      if (want != pend_class) begin
        pend_class = want;
        pend_samples = 20'd0;
      end
      total = 64'(pend_samples) + n;
      pend_samples = (total > 64'hFFFFF) ? 20'hFFFFF : total[19:0];
      if (64'(pend_samples) >= hold_samples(cur_class, want)) begin
        cur_class = want;
        pend_class = want;
        pend_samples = 20'd0;
        v.changed = 1'b1;
      end
    end
    v.cls = cur_class;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("[%0t] mismatch: %s, expected %0d, got %0d", $time, what, want_v, got_v);
    errs++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = '{RST_SILENT_FLOOR_MIN, RST_SILENT_FLOOR_CEILING, RST_LOUD_LEVEL_MAX,
              RST_LOUD_LEVEL_MIN, RST_SUB_BASS_LOUD_FLOOR, RST_SUB_BASS_SOFT_CEILING,
              RST_RATIO_FACTORS, RST_HOLD_TIMES};
      floor_level = 16'hFFFF;
      cur_class = CLASS_SILENT;
      pend_class = CLASS_SILENT;
      pend_samples = 20'd0;
      verdict_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected", 0, m_tdata[1:0]);
        end else begin
          oldest = verdict_q.pop_front();
          if (m_tdata[1:0] !== oldest.cls) begin
            report_mismatch("structure_class", oldest.cls, m_tdata[1:0]);
          end
          if (m_tuser !== oldest.changed) begin
            report_mismatch("class_changed", oldest.changed, m_tuser);
          end
          checked++;
          if (oldest.changed) begin
            changes++;
          end
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_SILENT_FLOOR_MIN:      cfg.silent_floor_min = wr_data[15:0];
          REG_SILENT_FLOOR_CEILING:  cfg.silent_floor_ceiling = wr_data[15:0];
          REG_LOUD_LEVEL_MAX:        cfg.loud_level_max = wr_data[15:0];
          REG_LOUD_LEVEL_MIN:        cfg.loud_level_min = wr_data[15:0];
          REG_SUB_BASS_LOUD_FLOOR:   cfg.sub_bass_loud_floor = wr_data[15:0];
          REG_SUB_BASS_SOFT_CEILING: cfg.sub_bass_soft_ceiling = wr_data[15:0];
          REG_RATIO_FACTORS:         cfg.ratio_factors = wr_data;
          REG_HOLD_TIMES:            cfg.hold_times = wr_data[59:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        verdict_q.push_back(classify_block(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                                           s_tuser, s_tdata[60:48]));
      end
    end
    outstanding <= verdict_q.size();
    fail_count <= errs;
    blocks_checked <= checked;
    changes_seen <= changes;
  end

endmodule

// File: dv/audio_level_structure_classifier_tb.sv
// Testbench top for the audio level structure classifier: stimulus, idling and the verdict.
module audio_level_structure_classifier_tb;
  import alsc_pkg::*;

  localparam int LATENCY      = 4;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_BLOCKS = 190;
  localparam int HOLD_OFF     = 300;

  localparam int SCENE_QUIET = 0;
  localparam int SCENE_SOFT  = 1;
  localparam int SCENE_LOUD  = 2;
  localparam int SCENE_NOISE = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [63:0] wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;

  int fail_count;
  int outstanding;
  int blocks_checked;
  int changes_seen;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_off_reqs = 0;
  int hold_offs_done = 0;
  int hold_off_left = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  audio_level_structure_classifier u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  audio_level_structure_classifier_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .blocks_checked (blocks_checked),
    .changes_seen   (changes_seen)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_left > 0) begin
      m_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_offs_done != hold_off_reqs) begin
      m_tready <= 1'b0;
      hold_off_left <= HOLD_OFF;
      hold_offs_done <= hold_offs_done + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
               QUIET_LIMIT, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_block(input logic [15:0] rms, input logic [15:0] peak,
                            input logic [15:0] share, input logic ringing,
                            input logic [12:0] n);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'd0, n, share, peak, rms};
    s_tuser <= ringing;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_one(input logic [2:0] idx, input logic [63:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    write_one(REG_SILENT_FLOOR_MIN, 64'(c.silent_floor_min));
    write_one(REG_SILENT_FLOOR_CEILING, 64'(c.silent_floor_ceiling));
    write_one(REG_LOUD_LEVEL_MAX, 64'(c.loud_level_max));
    write_one(REG_LOUD_LEVEL_MIN, 64'(c.loud_level_min));
    write_one(REG_SUB_BASS_LOUD_FLOOR, 64'(c.sub_bass_loud_floor));
    write_one(REG_SUB_BASS_SOFT_CEILING, 64'(c.sub_bass_soft_ceiling));
    write_one(REG_RATIO_FACTORS, c.ratio_factors);
    write_one(REG_HOLD_TIMES, 64'(c.hold_times));
    wr_en <= 1'b0;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [59:0] short_holds(input int top);
    logic [59:0] h;
    for (int i = 0; i < 5; i++) begin
      h[12 * i +: 12] = 12'($urandom_range(top));
    end
    return h;
  endfunction

  function automatic cfg_t phase_config(input int p);
    cfg_t c;
    c = '{RST_SILENT_FLOOR_MIN, RST_SILENT_FLOOR_CEILING, RST_LOUD_LEVEL_MAX,
          RST_LOUD_LEVEL_MIN, RST_SUB_BASS_LOUD_FLOOR, RST_SUB_BASS_SOFT_CEILING,
          RST_RATIO_FACTORS, RST_HOLD_TIMES};
    case (p)
      0: begin
        c.ratio_factors = {16'($urandom_range(8192, 1024)), 16'($urandom_range(4096, 1024)),
                           16'($urandom_range(400, 50)), 16'($urandom_range(12288, 4096))};
        c.hold_times = short_holds(12);
      end
      1: c = '0;
      2: c = '1;
      3: begin
        c.silent_floor_min = 16'($urandom);
        c.silent_floor_ceiling = 16'($urandom);
        c.loud_level_max = 16'($urandom);
        c.loud_level_min = 16'($urandom);
        c.sub_bass_loud_floor = 16'($urandom);
        c.sub_bass_soft_ceiling = 16'($urandom);
        c.ratio_factors = {$urandom, $urandom};
        c.hold_times = short_holds(31);
      end
      4: c.hold_times = short_holds(8);
      default: begin
        c.silent_floor_ceiling = 16'($urandom_range(4000, 500));
        c.ratio_factors[63:48] = 16'($urandom_range(65535, 30000));
        c.hold_times = short_holds(3);
      end
    endcase
    return c;
  endfunction

  // Runs of blocks aimed at one class, so that the debounce counts up and commits,
  // mixed with runs of unconstrained blocks.
  task automatic play_phase(input int blocks);
    int sent;
    int run;
    int pick;
    int scene;
    logic [15:0] rms;
    logic [15:0] peak;
    logic [15:0] share;
    logic        ringing;
    logic [12:0] n;
    sent = 0;
    while (sent < blocks) begin
      pick = $urandom_range(9);
      scene = (pick < 3) ? SCENE_QUIET : (pick < 6) ? SCENE_SOFT :
              (pick < 9) ? SCENE_LOUD : SCENE_NOISE;
      run = $urandom_range(12, 1);
      repeat (run) begin
        n = ($urandom_range(9) == 0) ? 13'($urandom_range(8191)) :
            13'($urandom_range(1024, 16));
        peak = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
        share = 16'($urandom);
        ringing = ($urandom_range(4) == 0);
        rms = 16'($urandom);
        case (scene)
          SCENE_QUIET: begin
            rms = 16'($urandom_range(1500));
            ringing = ($urandom_range(7) == 0);
            peak = ($urandom_range(3) == 0) ? 16'($urandom_range(20000)) : 16'd0;
          end
          SCENE_SOFT: begin
            rms = 16'($urandom_range(12000, 1500));
            share = 16'($urandom_range(19000));
          end
          SCENE_LOUD: rms = 16'($urandom_range(65535, 12000));
          default: ;
        endcase
        send_block(rms, peak, share, ringing, n);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: floor snap-down, creep, override bands and block length limits.
    send_block(16'd0, 16'd0, 16'd0, 1'b0, 13'd0);
    send_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 13'h1FFF);
    send_block(16'd400, 16'd0, 16'd0, 1'b0, 13'd64);
    send_block(16'd401, 16'd0, 16'd0, 1'b1, 13'd64);
    send_block(16'd4, 16'd0, 16'd0, 1'b0, 13'd64);
    send_block(16'd5, 16'd0, 16'd0, 1'b0, 13'd64);
    send_block(16'd1310, 16'd0, 16'd0, 1'b0, 13'd4097);
    send_block(16'd1311, 16'd0, 16'd0, 1'b0, 13'd4096);
    send_block(16'd2000, 16'd0, 16'd39322, 1'b0, 13'd1);
    send_block(16'd5000, 16'd0, 16'd19661, 1'b0, 13'd4096);
    send_block(16'd5000, 16'd0, 16'd19662, 1'b0, 13'd4096);
    send_block(16'd20000, 16'd0, 16'd20000, 1'b0, 13'd4096);
    send_block(16'd3300, 16'd1, 16'd30000, 1'b0, 13'd4096);
    send_block(16'd40000, 16'd65535, 16'd0, 1'b1, 13'd4096);
    settle();

    // Zero holds: every wanted change commits on its first block, even with no samples.
    write_one(REG_HOLD_TIMES, 64'd0);
    wr_en <= 1'b0;
    send_block(16'd0, 16'd0, 16'd0, 1'b0, 13'd1);
    send_block(16'd30000, 16'd0, 16'd0, 1'b0, 13'd0);
    send_block(16'd5000, 16'd0, 16'd0, 1'b0, 13'd1);
    send_block(16'd0, 16'd0, 16'd0, 1'b0, 13'd1);
    send_block(16'd0, 16'd0, 16'd0, 1'b1, 13'd8);
    send_block(16'd0, 16'd0, 16'd65535, 1'b0, 13'd1);
    send_block(16'd0, 16'd0, 16'd0, 1'b0, 13'd4096);
    send_block(16'd1000, 16'd65535, 16'd65535, 1'b0, 13'd2);
    settle();

    for (int p = 0; p < 6; p++) begin
      write_config(phase_config(p));
      if (p < 2) begin
        tx_idle_pct = 38;
        rx_idle_pct <= 62;
      end else if (p < 4) begin
        tx_idle_pct = 62;
        rx_idle_pct <= 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (p == 4) begin
        hold_off_reqs <= hold_off_reqs + 1;
      end
      play_phase(PHASE_BLOCKS);
      settle();
    end

    $display("Checked %0d blocks over six register settings plus reset and zero-hold runs;",
             blocks_checked);
    $display("%0d class changes committed, one receiver hold-off of %0d cycles.",
             changes_seen, HOLD_OFF);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
